>>> rtl/q24_pkg.sv
// ----------------------------------------------------------------------------
// q24_pkg
// Shared types, constants and helper functions of the Q24.8 arithmetic unit.
// ----------------------------------------------------------------------------
package q24_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	localparam int NUM_W     = DATA_W + FRAC_BITS;	// dividend and quotient width
	localparam int PROD_W    = 2 * DATA_W;

	typedef enum logic [3:0] {
		ACT_ADD    = 4'd0,
		ACT_SUB    = 4'd1,
		ACT_MUL    = 4'd2,
		ACT_DIV    = 4'd3,
		ACT_GT     = 4'd4,
		ACT_LT     = 4'd5,
		ACT_GE     = 4'd6,
		ACT_LE     = 4'd7,
		ACT_EQ     = 4'd8,
		ACT_NE     = 4'd9,
		ACT_MIN    = 4'd10,
		ACT_MAX    = 4'd11,
		ACT_INC    = 4'd12,
		ACT_DEC    = 4'd13,
		ACT_TO_INT = 4'd14
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic [1:0]         status;
	} res_t;

	// Control carried alongside the division cells.
	typedef struct packed {
		res_t res;
		logic is_div;
		logic neg;
	} ctl_t;

	// Division state: partial remainder, shifting dividend/quotient, divisor.
	typedef struct packed {
		logic [DATA_W:0]   rem;
		logic [NUM_W-1:0]  nq;
		logic [DATA_W-1:0] den;
	} div_t;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// Clamp a 33-bit signed sum to 32 bits.
	function automatic res_t clamp33(input logic [32:0] v);
		res_t r;
		r.compare_true = 1'b0;
		r.status       = ST_OK;
		r.result_value = v[31:0];
		if (v[32] != v[31]) begin
			r.status       = ST_OVF;
			r.result_value = v[32] ? SAT_MIN : SAT_MAX;
		end
		return r;
	endfunction

	// Apply a sign to a magnitude with saturation.
	function automatic res_t from_mag(input logic neg, input logic [PROD_W-1:0] mag);
		res_t r;
		r.compare_true = 1'b0;
		r.status       = ST_OK;
		if (!neg) begin
			if (mag > PROD_W'(SAT_MAX)) begin
				r.status       = ST_OVF;
				r.result_value = SAT_MAX;
			end else begin
				r.result_value = mag[31:0];
			end
		end else begin
			if (mag > PROD_W'(SAT_MIN)) begin
				r.status       = ST_OVF;
				r.result_value = SAT_MIN;
			end else begin
				r.result_value = ~mag[31:0] + 32'd1;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/q24_front.sv
// ----------------------------------------------------------------------------
// q24_front
// Two-stage front end: magnitudes and product, then all non-divide results
// and the divider setup.
// ----------------------------------------------------------------------------
module q24_front import q24_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t cmd,
	output logic out_valid,
	output ctl_t ctl_out,
	output div_t div_out
);

	logic [31:0]        ma, mb;
	logic               valid_s1;
	logic [3:0]         act_s1;
	logic signed [31:0] a_s1, b_s1;
	logic [31:0]        ma_s1, mb_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic               neg_s1;

	logic               valid_s2;
	ctl_t               ctl_s2, ctl_d;
	div_t               div_s2, div_d;
	logic [PROD_W-1:0]  mq;

	assign ma = cmd.operand_a[31] ? (~cmd.operand_a + 32'd1) : cmd.operand_a;
	assign mb = cmd.operand_b[31] ? (~cmd.operand_b + 32'd1) : cmd.operand_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		act_s1  <= cmd.action;
		a_s1    <= cmd.operand_a;
		b_s1    <= cmd.operand_b;
		ma_s1   <= ma;
		mb_s1   <= mb;
		neg_s1  <= cmd.operand_a[31] ^ cmd.operand_b[31];
		prod_s1 <= PROD_W'(ma) * PROD_W'(mb);
		ctl_s2  <= ctl_d;
		div_s2  <= div_d;
	end

	assign mq = (prod_s1 + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

	always_comb begin
		ctl_d.res.result_value = '0;
		ctl_d.res.compare_true = 1'b0;
		ctl_d.res.status       = ST_OK;
		ctl_d.is_div           = 1'b0;
		ctl_d.neg              = neg_s1;
		div_d.rem              = '0;
		div_d.den              = mb_s1;
		div_d.nq               = {ma_s1, {FRAC_BITS{1'b0}}} + NUM_W'(mb_s1 >> 1);
		unique case (act_s1)
			ACT_ADD: ctl_d.res = clamp33({a_s1[31], a_s1} + {b_s1[31], b_s1});
			ACT_SUB: ctl_d.res = clamp33({a_s1[31], a_s1} - {b_s1[31], b_s1});
			ACT_MUL: ctl_d.res = from_mag(neg_s1 && (mq != '0), mq);
			ACT_DIV: begin
				if (b_s1 == '0) begin
					ctl_d.res.status = ST_DIV0;
					if (a_s1 > 0)
						ctl_d.res.result_value = SAT_MAX;
					else if (a_s1 < 0)
						ctl_d.res.result_value = SAT_MIN;
				end else begin
					ctl_d.is_div = 1'b1;
				end
			end
			ACT_GT:     ctl_d.res.compare_true = (a_s1 >  b_s1);
			ACT_LT:     ctl_d.res.compare_true = (a_s1 <  b_s1);
			ACT_GE:     ctl_d.res.compare_true = (a_s1 >= b_s1);
			ACT_LE:     ctl_d.res.compare_true = (a_s1 <= b_s1);
			ACT_EQ:     ctl_d.res.compare_true = (a_s1 == b_s1);
			ACT_NE:     ctl_d.res.compare_true = (a_s1 != b_s1);
			ACT_MIN:    ctl_d.res.result_value = (a_s1 > b_s1) ? b_s1 : a_s1;
			ACT_MAX:    ctl_d.res.result_value = (a_s1 < b_s1) ? b_s1 : a_s1;
			ACT_INC:    ctl_d.res = clamp33({a_s1[31], a_s1} + 33'd1);
			ACT_DEC:    ctl_d.res = clamp33({a_s1[31], a_s1} - 33'd1);
			ACT_TO_INT: ctl_d.res.result_value = a_s1 >>> FRAC_BITS;
			default: ;
		endcase
	end

	assign out_valid = valid_s2;
	assign ctl_out   = ctl_s2;
	assign div_out   = div_s2;

endmodule

>>> rtl/q24_div_cell.sv
// ----------------------------------------------------------------------------
// q24_div_cell
// One restoring-division cell: develop one quotient bit and pass it on.
// ----------------------------------------------------------------------------
module q24_div_cell import q24_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ctl_t ctl_in,
	input  div_t div_in,
	output logic out_valid,
	output ctl_t ctl_out,
	output div_t div_out
);

	logic [DATA_W:0] trial;
	logic            ge;
	div_t            div_d;

	// Bring down the next dividend bit and try a subtract.
	assign trial = {div_in.rem[DATA_W-1:0], div_in.nq[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_in.den};

	always_comb begin
		div_d.den = div_in.den;
		div_d.rem = ge ? (trial - {1'b0, div_in.den}) : trial;
		div_d.nq  = {div_in.nq[NUM_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		ctl_out <= ctl_in;
		div_out <= div_d;
	end

endmodule

>>> rtl/q24_back.sv
// ----------------------------------------------------------------------------
// q24_back
// Output stage: sign and saturate the quotient, register the result.
// ----------------------------------------------------------------------------
module q24_back import q24_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  ctl_t ctl_in,
	input  div_t div_in,
	output logic out_valid,
	output res_t res_out
);

	res_t res_d;

	always_comb begin
		res_d = ctl_in.res;
		if (ctl_in.is_div)
			res_d = from_mag(ctl_in.neg && (div_in.nq != '0), PROD_W'(div_in.nq));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		res_out <= res_d;
	end

endmodule

>>> rtl/q24_8_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_top
// Signed Q24.8 arithmetic unit with a fully pipelined divider chain.
// ----------------------------------------------------------------------------
// Issue a command by raising start for one cycle; busy is always low, so a
// new command can be transferred on every clock. Every command returns one
// Q24.8 result in issue order, shown on result for one cycle with
// result_valid high. The receiver cannot stall: capture the result in the
// cycle it appears. The divider is a chain of NUM_W cells that each develop
// one quotient bit; all other operations travel down the same chain so that
// results stay in order. Two front stages form magnitudes, the 32x32
// product and every non-divide result; one back stage signs and saturates
// the quotient.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu_top import q24_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic result_valid,
	output res_t result
);

	logic [NUM_W:0] vld;
	ctl_t           ctl [NUM_W+1];
	div_t           dv  [NUM_W+1];

	// The pipeline never holds off a transfer.
	assign busy = 1'b0;

	// Prepare operands and finish every operation but divide.
	q24_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.cmd       (cmd),
		.out_valid (vld[0]),
		.ctl_out   (ctl[0]),
		.div_out   (dv[0])
	);

	// Advance every command through the divider chain, one quotient bit a cell.
	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		q24_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.ctl_in    (ctl[i]),
			.div_in    (dv[i]),
			.out_valid (vld[i+1]),
			.ctl_out   (ctl[i+1]),
			.div_out   (dv[i+1])
		);
	end

	// Sign, saturate and drive the result.
	q24_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[NUM_W]),
		.ctl_in    (ctl[NUM_W]),
		.div_in    (dv[NUM_W]),
		.out_valid (result_valid),
		.res_out   (result)
	);

endmodule
